FILE: rtl/irc_message_line_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the IRC line tokenizer
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef IRC_MESSAGE_LINE_TOKENIZER_MACROS_SVH
`define IRC_MESSAGE_LINE_TOKENIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IRCTOK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("irctok: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define IRCTOK_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("irctok: next-cycle check failed");

`endif

FILE: rtl/irctok_pkg.sv
// ----------------------------------------------------------------------------
// irctok_pkg
// Types, constants and the keyword matcher of the IRC line tokenizer.
// ----------------------------------------------------------------------------
package irctok_pkg;

  localparam int CMD_BYTES    = 7;
  localparam int CMD_IDX_W    = $clog2(CMD_BYTES);
  localparam int CMD_LEN_MAX  = 15;
  localparam int MAX_PARAMS   = 15;
  localparam int PARAM_CAP    = (MAX_PARAMS < 15) ? MAX_PARAMS : 15;
  localparam int QUEUE_DEPTH  = 2;
  localparam int NUM_KEYWORDS = 14;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic [3:0] CODE_UNKNOWN = 4'd0;
  localparam logic [3:0] CODE_SHOW    = 4'd14;

  localparam logic [0:0] REG_IDX_DEBUG = 1'b0;

  typedef logic [8*CMD_BYTES-1:0] cmd_text_t;

  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_CMD   = 4'b0010,
    PH_PARAM = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_NONE  = 3'd0,
    ROLE_CMD   = 3'd1,
    ROLE_PARAM = 3'd2,
    ROLE_COLON = 3'd3,
    ROLE_TRAIL = 3'd4
  } role_t;

  // Classified input item as it travels through the queue.
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       is_space;
    logic       is_tab;
    logic       is_colon;
    logic       is_lower;
  } item_t;

  typedef struct packed {
    logic [7:0] char_out;
    role_t      role;
    logic       token_first;
    logic [3:0] param_index;
    logic       command_valid;
    logic [3:0] command_code;
    logic       line_done;
    logic [3:0] param_count;
    logic       has_trailing;
    logic       param_overflow;
  } result_t;

  // Keyword text, first character in the lowest byte, zero padded.
  localparam cmd_text_t KW_TEXT [NUM_KEYWORDS] = '{
    56'h00000053534150,  // PASS
    56'h0000004B43494E,  // NICK
    56'h00000052455355,  // USER
    56'h0000004E494F4A,  // JOIN
    56'h00000054524150,  // PART
    56'h0000004B43494B,  // KICK
    56'h00455449564E49,  // INVITE
    56'h00004349504F54,  // TOPIC
    56'h00000045444F4D,  // MODE
    56'h47534D56495250,  // PRIVMSG
    56'h00000054495551,  // QUIT
    56'h000000004F4857,  // WHO
    56'h00000000504143,  // CAP
    56'h000000574F4853   // SHOW
  };

  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd6, 4'd5, 4'd4, 4'd7, 4'd4, 4'd3, 4'd3, 4'd4
  };

  localparam logic [3:0] KW_CODE [NUM_KEYWORDS] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13,
    CODE_SHOW
  };

  // The stored text is zero beyond its length, so a full-width compare plus a
  // length compare is an exact match.
  function automatic logic [3:0] match_cmd(input cmd_text_t text, input logic [3:0] len,
                                           input logic dbg_en);
    logic [3:0] code;
    code = CODE_UNKNOWN;
    if (len != 4'd0 && len <= 4'(CMD_BYTES)) begin
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
        if ((KW_CODE[k] != CODE_SHOW || dbg_en) && KW_LEN[k] == len && KW_TEXT[k] == text) begin
          code = KW_CODE[k];
        end
      end
    end
    return code;
  endfunction

endpackage

FILE: rtl/irctok_fifo.sv
// ----------------------------------------------------------------------------
// irctok_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`include "irc_message_line_tokenizer_macros.svh"

module irctok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  irctok_pkg::item_t   push_item,
  output logic                not_full,
  output logic                head_valid,
  output irctok_pkg::item_t   head,
  input  logic                pop
);
  import irctok_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign not_full   = (count != CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `IRCTOK_ASSERT_IMP(a_no_underflow, pop, count != '0)
  `IRCTOK_ASSERT_IMP(a_no_overflow, push, count != CW'(QUEUE_DEPTH) || pop)
  `IRCTOK_ASSERT_NXT(a_count_grows, push && !pop, count == $past(count) + 1'b1)

endmodule

FILE: rtl/irctok_front.sv
// ----------------------------------------------------------------------------
// irctok_front
// Accepts input items and classifies each byte for the back part.
// ----------------------------------------------------------------------------
module irctok_front (
  input  logic              s_tvalid,
  input  logic              s_tlast,
  input  logic [7:0]        s_tdata,
  input  logic              queue_ready,
  output logic              push,
  output irctok_pkg::item_t push_item
);
  import irctok_pkg::*;

  assign push = s_tvalid && queue_ready;

  always_comb begin
    push_item.ch       = s_tdata;
    push_item.eol      = s_tlast;
    push_item.is_space = (s_tdata == CH_SPACE);
    push_item.is_tab   = (s_tdata == CH_TAB);
    push_item.is_colon = (s_tdata == CH_COLON);
    push_item.is_lower = (s_tdata >= CH_LOWER_A) && (s_tdata <= CH_LOWER_Z);
  end

endmodule

FILE: rtl/irctok_back.sv
// ----------------------------------------------------------------------------
// irctok_back
// Line state machine: tags each queued item and holds the result register.
// ----------------------------------------------------------------------------
`include "irc_message_line_tokenizer_macros.svh"

module irctok_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                dbg_en,
  input  logic                head_valid,
  input  irctok_pkg::item_t   head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output irctok_pkg::result_t out_data
);
  import irctok_pkg::*;

  phase_t     phase, phase_next, phase_eff;
  cmd_text_t  cmd_text, cmd_text_next;
  logic [3:0] cmd_len, cmd_len_next;
  logic       prev_space, prev_space_next;
  logic       inside_token, inside_token_next;
  logic [3:0] params_seen, params_seen_next;
  logic       trailing_seen, trailing_seen_next;
  logic [3:0] token_index, token_index_next;
  logic       overflow_seen, overflow_seen_next;
  logic [3:0] code_now;
  logic [7:0] upper_ch;
  result_t    res;

  assign pop      = head_valid && (!out_valid || out_ready);
  assign code_now = match_cmd(cmd_text, cmd_len, dbg_en);
  assign upper_ch = head.is_lower ? (head.ch - CASE_DELTA) : head.ch;

  // A non-blank byte in leading whitespace is already the first command byte.
  assign phase_eff = (phase == PH_LEAD && !head.is_space && !head.is_tab) ? PH_CMD : phase;

  always_comb begin
    phase_next         = phase;
    cmd_text_next      = cmd_text;
    cmd_len_next       = cmd_len;
    prev_space_next    = prev_space;
    inside_token_next  = inside_token;
    params_seen_next   = params_seen;
    trailing_seen_next = trailing_seen;
    token_index_next   = token_index;
    overflow_seen_next = overflow_seen;
    res                = '0;
    res.role           = ROLE_NONE;

    if (head.eol) begin
      if (phase == PH_LEAD || phase == PH_CMD) begin
        res.command_valid = 1'b1;
        res.command_code  = code_now;
      end
      res.line_done      = 1'b1;
      res.param_count    = params_seen;
      res.has_trailing   = trailing_seen;
      res.param_overflow = overflow_seen;
      phase_next         = PH_LEAD;
      cmd_text_next      = '0;
      cmd_len_next       = '0;
      prev_space_next    = 1'b0;
      inside_token_next  = 1'b0;
      params_seen_next   = '0;
      trailing_seen_next = 1'b0;
      token_index_next   = '0;
      overflow_seen_next = 1'b0;
    end else begin
      res.char_out = head.ch;
      phase_next   = phase_eff;
      case (phase_eff)
        PH_LEAD: begin
          res.role = ROLE_NONE;
        end
        PH_CMD: begin
          if (head.is_space) begin
            res.command_valid = 1'b1;
            res.command_code  = code_now;
            phase_next        = PH_PARAM;
            prev_space_next   = 1'b1;
          end else begin
            res.char_out = upper_ch;
            res.role     = ROLE_CMD;
            if (cmd_len < 4'(CMD_BYTES)) begin
              cmd_text_next[8*cmd_len[CMD_IDX_W-1:0] +: 8] = upper_ch;
            end
            if (cmd_len < 4'(CMD_LEN_MAX)) begin
              cmd_len_next = cmd_len + 4'd1;
            end
          end
        end
        PH_PARAM: begin
          if (head.is_colon && prev_space) begin
            res.role           = ROLE_COLON;
            trailing_seen_next = 1'b1;
            phase_next         = PH_TRAIL;
          end else if (head.is_space) begin
            inside_token_next = 1'b0;
            prev_space_next   = 1'b1;
          end else begin
            res.role = ROLE_PARAM;
            if (!inside_token) begin
              res.token_first  = 1'b1;
              token_index_next = params_seen;
              if (params_seen < 4'(PARAM_CAP)) begin
                params_seen_next = params_seen + 4'd1;
              end else begin
                overflow_seen_next = 1'b1;
              end
              inside_token_next = 1'b1;
            end
            res.param_index = token_index_next;
            prev_space_next = 1'b0;
          end
        end
        PH_TRAIL: begin
          res.role = ROLE_TRAIL;
        end
        default: begin
          res.role = ROLE_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      phase         <= PH_LEAD;
      cmd_text      <= '0;
      cmd_len       <= '0;
      prev_space    <= 1'b0;
      inside_token  <= 1'b0;
      params_seen   <= '0;
      trailing_seen <= 1'b0;
      token_index   <= '0;
      overflow_seen <= 1'b0;
    end else if (pop) begin
      out_valid     <= 1'b1;
      phase         <= phase_next;
      cmd_text      <= cmd_text_next;
      cmd_len       <= cmd_len_next;
      prev_space    <= prev_space_next;
      inside_token  <= inside_token_next;
      params_seen   <= params_seen_next;
      trailing_seen <= trailing_seen_next;
      token_index   <= token_index_next;
      overflow_seen <= overflow_seen_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

  `IRCTOK_ASSERT_NXT(a_eol_clears, pop && head.eol, phase == PH_LEAD && params_seen == '0)
  `IRCTOK_ASSERT_NXT(a_trail_sticks, pop && phase == PH_TRAIL && !head.eol, phase == PH_TRAIL)
  `IRCTOK_ASSERT_IMP(a_ovf_at_cap, overflow_seen, params_seen == 4'(PARAM_CAP))

endmodule

FILE: rtl/irc_message_line_tokenizer.sv
// An accepted item is written to the queue; when it is popped, its result is registered and m_tvalid rises.
// Throughput: one item per cycle while m_tready allows, set by the line state
// update in the back part; a two-entry queue lets input and output stall apart.
// Reset (rst, synchronous): clears the queue, the line state, the result valid
// flag and the debug register; there is no clearing pass.
// ----------------------------------------------------------------------------
// irc_message_line_tokenizer
// Tags each byte of an IRC message line with its role and decodes the command.
// ----------------------------------------------------------------------------
module irc_message_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,   // end_of_line
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] char_out, [8] token_first, [12:9] param_index, [13] command_valid,
  // [17:14] command_code, [21:18] param_count, [22] has_trailing,
  // [23] param_overflow
  output logic [23:0] m_tdata,
  output logic [2:0]  m_tuser,   // [2:0] role
  output logic        m_tlast,   // line_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import irctok_pkg::*;

  logic    enable_debug_command;
  logic    push;
  item_t   push_item;
  logic    queue_ready;
  logic    head_valid;
  item_t   head;
  logic    pop;
  result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_IDX_DEBUG) ? {31'd0, enable_debug_command} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_debug_command <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2:2] == REG_IDX_DEBUG) begin
      enable_debug_command <= pwdata[0];
    end
  end

  assign s_tready = queue_ready;

  irctok_front u_front (
    .s_tvalid    (s_tvalid),
    .s_tlast     (s_tlast),
    .s_tdata     (s_tdata),
    .queue_ready (queue_ready),
    .push        (push),
    .push_item   (push_item)
  );

  irctok_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .not_full   (queue_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  irctok_back u_back (
    .clk        (clk),
    .rst        (rst),
    .dbg_en     (enable_debug_command),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (res)
  );

  assign m_tdata = {res.param_overflow, res.has_trailing, res.param_count, res.command_code,
                    res.command_valid, res.param_index, res.token_first, res.char_out};
  assign m_tuser = res.role;
  assign m_tlast = res.line_done;

endmodule
